[rtl/gpiq_pkg.sv]
// Shared types and constants for the gamepad input qualifier.
package gpiq_pkg;

  // Fixed field widths of the sample and result items.
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned BTN_W    = 16;
  localparam int unsigned AXIS_W   = 8;
  localparam int unsigned AXES_MAX = 4;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 160;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Raw stick value that reads as the centre position.
  localparam logic [AXIS_W-1:0] STICK_CENTRE = 8'd128;

  // Bit offsets of the result fields in out_tdata.
  localparam int unsigned OUT_PRESSED_LSB   = 48;
  localparam int unsigned OUT_RELEASED_LSB  = 64;
  localparam int unsigned OUT_REL_AFTER_LSB = 80;
  localparam int unsigned OUT_HELD_LSB      = 96;
  localparam int unsigned OUT_RPT_LSB       = 112;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEAD_ZONE      = 3'd0,
    CFG_HOLD_TIME      = 3'd1,
    CFG_REPEAT_DELAY   = 3'd2,
    CFG_BUTTON_DISABLE = 3'd3,
    CFG_STICK_DISABLE  = 3'd4
  } cfg_idx_t;

  // Per-button control from the top level to a button lane.
  typedef struct packed {
    logic step;  // the registered sample is consumed this cycle
    logic down;  // button is down in the current sample
    logic was;   // button was down in the previous sample
  } lane_ctl_t;

  // Per-button qualification results from a lane.
  typedef struct packed {
    logic pressed;
    logic released;
    logic rel_after;
    logic held;
    logic rpt;
  } lane_flags_t;

endpackage

[rtl/gpiq_button_lane.sv]
// One button's press and repeat timestamps and its edge, hold and repeat tests.
module gpiq_button_lane
  import gpiq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  lane_ctl_t         ctl,
  input  logic [TIME_W-1:0] now,
  input  logic [TIME_W-1:0] hold_time,
  input  logic [TIME_W-1:0] repeat_delay,
  output lane_flags_t       flags
);

  logic [TIME_W-1:0] press_time_r;
  logic [TIME_W-1:0] press_time_nxt;
  logic [TIME_W-1:0] repeat_time_r;
  logic [TIME_W-1:0] repeat_time_nxt;
  logic [TIME_W-1:0] press_age;
  logic [TIME_W-1:0] repeat_age;
  logic              old_press_due;

  // Elapsed times wrap modulo the timestamp width.
  assign press_age     = now - press_time_r;
  assign repeat_age    = now - repeat_time_r;
  assign old_press_due = (press_age >= hold_time);

  // Edge, hold and repeat tests. A press edge restarts the press time at
  // now, so the held test on that sample sees zero elapsed time.
  always_comb begin
    flags.pressed   = ctl.down & ~ctl.was;
    flags.released  = ~ctl.down & ctl.was;
    flags.rel_after = flags.released & old_press_due;
    flags.held      = ctl.down & (flags.pressed ? (hold_time == '0) : old_press_due);
    flags.rpt       = ctl.down & (repeat_age >= repeat_delay);
  end

  // Timestamps move to now on a press edge, a held hit or a repeat hit.
  always_comb begin
    press_time_nxt  = press_time_r;
    repeat_time_nxt = repeat_time_r;
    if (ctl.step && (flags.pressed || flags.held)) begin
      press_time_nxt = now;
    end
    if (ctl.step && flags.rpt) begin
      repeat_time_nxt = now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_time_r  <= '0;
      repeat_time_r <= '0;
    end else begin
      press_time_r  <= press_time_nxt;
      repeat_time_r <= repeat_time_nxt;
    end
  end

endmodule

[rtl/gpiq_axis.sv]
// Centres one raw stick byte and applies the deadzone.
module gpiq_axis
  import gpiq_pkg::*;
(
  input  logic        [AXIS_W-1:0] raw,
  input  logic        [AXIS_W-1:0] dead_zone,
  output logic signed [AXIS_W-1:0] value
);

  logic signed [AXIS_W-1:0] centred;
  logic        [AXIS_W-1:0] magnitude;

  // Subtracting the centre of 128 only flips the top bit.
  assign centred = signed'(raw ^ STICK_CENTRE);

  // Magnitude fits in eight unsigned bits, full left deflection gives 128.
  assign magnitude = centred[AXIS_W-1] ? (~centred + 1'b1) : centred;

  assign value = (magnitude < dead_zone) ? '0 : centred;

endmodule

[rtl/gamepad_input_qualifier.sv]
// Top level of the gamepad input qualifier.
// Takes one pad sample per cycle when the output is not stalled and gives one
// result per sample: the sample is registered, then all button tests, stick
// deadzones and timestamp updates run in one pass into the result register,
// which decouples the output so a new sample is taken while a finished result
// waits. Each button compares wrapped 32-bit elapsed times against hold_time_ms
// and repeat_delay_ms; a press edge restarts the press time, as does a held-for
// hit. Stick outputs are the raw bytes minus 128 (zero inside the deadzone) and
// ignore the stick disable mask, which only affects the forwarded bytes.
// Configuration writes are always taken and should be made while no sample is
// in flight; unknown indexes are ignored.
module gamepad_input_qualifier
  import gpiq_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 16,
  parameter int unsigned NUM_AXES    = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Sample channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // sample_time_ms[31:0], button_word[47:32], right_x_raw[55:48],
  // right_y_raw[63:56], left_x_raw[71:64], left_y_raw[79:72]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // forwarded_buttons[15:0], forwarded_sticks[47:16], pressed_mask[63:48],
  // released_mask[79:64], released_after_mask[95:80], held_for_mask[111:96],
  // repeat_mask[127:112], stick_right_x[135:128], stick_right_y[143:136],
  // stick_left_x[151:144], stick_left_y[159:152]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [AXIS_W-1:0]   dead_zone_r;
  logic [TIME_W-1:0]   hold_time_r;
  logic [TIME_W-1:0]   repeat_delay_r;
  logic [BTN_W-1:0]    button_disable_r;
  logic [AXES_MAX-1:0] stick_disable_r;

  // Input register and pipeline control.
  logic                 in_valid_r;
  logic                 in_valid_nxt;
  logic [IN_DATA_W-1:0] in_data_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                 in_xfer;
  logic                 advance;
  logic                 step;

  // Unpacked sample fields.
  logic [TIME_W-1:0] now;
  logic [BTN_W-1:0]  cur_buttons;
  logic [AXIS_W-1:0] raw_axis [AXES_MAX];

  // Previous button word.
  logic [BTN_W-1:0] prev_buttons_r;

  // Per-button results.
  logic [BTN_W-1:0] pressed;
  logic [BTN_W-1:0] released;
  logic [BTN_W-1:0] rel_after;
  logic [BTN_W-1:0] held;
  logic [BTN_W-1:0] rpt;

  // Stick results.
  logic [AXIS_W-1:0] stick_value [AXES_MAX];
  logic [AXIS_W-1:0] fwd_axis    [AXES_MAX];

  logic [OUT_DATA_W-1:0] result;

  // Configuration writes are accepted every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r      <= '0;
      hold_time_r      <= '0;
      repeat_delay_r   <= '0;
      button_disable_r <= '0;
      stick_disable_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEAD_ZONE:      dead_zone_r      <= cfg_data[AXIS_W-1:0];
        CFG_HOLD_TIME:      hold_time_r      <= cfg_data[TIME_W-1:0];
        CFG_REPEAT_DELAY:   repeat_delay_r   <= cfg_data[TIME_W-1:0];
        CFG_BUTTON_DISABLE: button_disable_r <= cfg_data[BTN_W-1:0];
        CFG_STICK_DISABLE:  stick_disable_r  <= cfg_data[AXES_MAX-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the result register frees when empty or when taken.
  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      prev_buttons_r <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (step) begin
        prev_buttons_r <= cur_buttons;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_data_r <= in_tdata;
    end
    if (step) begin
      out_data_r <= result;
    end
  end

  // Sample fields.
  assign now         = in_data_r[31:0];
  assign cur_buttons = in_data_r[47:32];
  assign raw_axis[0] = in_data_r[55:48];
  assign raw_axis[1] = in_data_r[63:56];
  assign raw_axis[2] = in_data_r[71:64];
  assign raw_axis[3] = in_data_r[79:72];

  // One lane per configured button; the others report nothing.
  for (genvar b = 0; b < BTN_W; b++) begin : g_btn
    if (b < NUM_BUTTONS) begin : g_lane
      lane_ctl_t   ctl;
      lane_flags_t flags;

      assign ctl.step = step;
      assign ctl.down = cur_buttons[b];
      assign ctl.was  = prev_buttons_r[b];

      gpiq_button_lane u_lane (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .now          (now),
        .hold_time    (hold_time_r),
        .repeat_delay (repeat_delay_r),
        .flags        (flags)
      );

      assign pressed[b]   = flags.pressed;
      assign released[b]  = flags.released;
      assign rel_after[b] = flags.rel_after;
      assign held[b]      = flags.held;
      assign rpt[b]       = flags.rpt;
    end else begin : g_none
      assign pressed[b]   = 1'b0;
      assign released[b]  = 1'b0;
      assign rel_after[b] = 1'b0;
      assign held[b]      = 1'b0;
      assign rpt[b]       = 1'b0;
    end
  end

  // Sticks: deadzone on the raw bytes, centring of disabled forwarded bytes.
  for (genvar a = 0; a < AXES_MAX; a++) begin : g_axis
    if (a < NUM_AXES) begin : g_on
      logic signed [AXIS_W-1:0] value;

      gpiq_axis u_axis (
        .raw       (raw_axis[a]),
        .dead_zone (dead_zone_r),
        .value     (value)
      );

      assign stick_value[a] = value;
      assign fwd_axis[a]    = stick_disable_r[a] ? STICK_CENTRE : raw_axis[a];
    end else begin : g_off
      assign stick_value[a] = '0;
      assign fwd_axis[a]    = raw_axis[a];
    end
  end

  // Result packing.
  assign result = {stick_value[3], stick_value[2], stick_value[1], stick_value[0],
                   rpt, held, rel_after, released, pressed,
                   fwd_axis[3], fwd_axis[2], fwd_axis[1], fwd_axis[0],
                   cur_buttons & ~button_disable_r};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/gpiq_checker.sv]
// Port-level checks for the gamepad input qualifier and their bind.
module gpiq_checker
  import gpiq_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic [BTN_W-1:0] pressed;
  logic [BTN_W-1:0] released;
  logic [BTN_W-1:0] rel_after;
  logic [BTN_W-1:0] held;
  logic [BTN_W-1:0] rpt;

  assign pressed   = out_tdata[OUT_PRESSED_LSB   +: BTN_W];
  assign released  = out_tdata[OUT_RELEASED_LSB  +: BTN_W];
  assign rel_after = out_tdata[OUT_REL_AFTER_LSB +: BTN_W];
  assign held      = out_tdata[OUT_HELD_LSB      +: BTN_W];
  assign rpt       = out_tdata[OUT_RPT_LSB       +: BTN_W];

  // A stalled result stays and holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A button cannot press and release in the same sample.
  a_edges_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pressed & released) == '0)
    else $error("press and release edge on one button");

  // Released-after is only reported on a release edge.
  a_rel_after_subset: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (rel_after & ~released) == '0)
    else $error("released-after without release edge");

  // Held and repeat need the button down, so never on a release edge.
  a_down_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((held | rpt) & released) == '0)
    else $error("held or repeat on a released button");

endmodule

bind gamepad_input_qualifier gpiq_checker u_gpiq_checker (.*);
